>>> hw/rtl/markup_entity_stripper_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the markup entity stripper
// Concurrent property wrappers used by mes_burst, which checks itself.
// ----------------------------------------------------------------------------
`ifndef MARKUP_ENTITY_STRIPPER_TOP_ASSERT_SVH
`define MARKUP_ENTITY_STRIPPER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MES_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("markup entity stripper: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MES_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("markup entity stripper: assertion failed");

`endif

>>> hw/rtl/mes_pkg.sv
// ----------------------------------------------------------------------------
// Markup entity stripper package
// Widths, character codes, the entity table and the result burst type.
// ----------------------------------------------------------------------------
package mes_pkg;

    localparam int BYTE_W      = 8;
    localparam int PEND_DEPTH  = 5;
    localparam int MAX_RES     = 6;
    localparam int ENT_NUM     = 5;
    localparam int ENT_MAX_LEN = 6;
    localparam int CNT_W       = 3;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [CNT_W-1:0]  t_cnt;

    localparam t_byte CH_LT  = 8'h3C;  // '<'
    localparam t_byte CH_GT  = 8'h3E;  // '>'
    localparam t_byte CH_AMP = 8'h26;  // '&'
    localparam t_byte CH_B_L = 8'h62;  // 'b'
    localparam t_byte CH_B_U = 8'h42;  // 'B'
    localparam t_byte CH_R_L = 8'h72;  // 'r'
    localparam t_byte CH_R_U = 8'h52;  // 'R'
    localparam t_byte CH_NL  = 8'h0A;

    // Entity spellings, padded with zero beyond their length.
    localparam t_byte ENT_TXT [ENT_NUM][ENT_MAX_LEN] = '{
        '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},  // &amp;
        '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},  // &lt;
        '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},  // &gt;
        '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},  // &quot;
        '{8'h26, 8'h23, 8'h33, 8'h39, 8'h3B, 8'h00}   // &#39;
    };
    localparam t_cnt  ENT_LEN [ENT_NUM] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd5};
    localparam t_byte ENT_DEC [ENT_NUM] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27};

    // All the results caused by one input item.
    typedef struct packed {
        logic [MAX_RES-1:0][BYTE_W-1:0] chars;
        t_cnt                           num;
        logic                           has;
        logic                           fin;
    } t_burst;

endpackage

>>> hw/rtl/mes_stream_if.sv
// ----------------------------------------------------------------------------
// Markup entity stripper stream interfaces
// Valid/ready channels for text bytes in and decoded results out.
// ----------------------------------------------------------------------------
interface mes_in_if;
    logic                          valid;
    logic                          ready;
    logic [mes_pkg::BYTE_W-1:0]    text_byte;
    logic                          final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface mes_out_if;
    logic                          valid;
    logic                          ready;
    logic [mes_pkg::BYTE_W-1:0]    out_char;
    logic                          has_char;
    logic                          run_end;
    logic                          text_done;

    modport source (output valid, output out_char, output has_char, output run_end,
                    output text_done, input ready);
    modport sink   (input valid, input out_char, input has_char, input run_end,
                    input text_done, output ready);
endinterface

>>> hw/rtl/mes_scan.sv
// ----------------------------------------------------------------------------
// Markup entity stripper scanner
// Holds the tag and entity state and forms the result burst of each item.
// ----------------------------------------------------------------------------
module mes_scan (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  mes_pkg::t_byte  i_text_byte,
    input  logic            i_final_byte,
    output mes_pkg::t_burst o_burst
);
    import mes_pkg::*;

    typedef enum logic [2:0] {
        MODE_NORMAL   = 3'd0,
        MODE_ENTITY   = 3'd1,
        MODE_TAG_OPEN = 3'd2,
        MODE_TAG_B    = 3'd3,
        MODE_TAG_BODY = 3'd4
    } t_mode;

    t_mode r_mode, n_mode;
    t_cnt  r_cnt, n_cnt;
    t_byte r_pend [PEND_DEPTH];

    t_cnt               cnt;
    logic [ENT_NUM-1:0] pfx_ok;
    logic [ENT_NUM-1:0] full;
    t_byte              dec;
    logic               is_lt, is_amp, is_gt;
    t_mode              f_mode;
    logic               f_lit;
    logic               pend_wr;
    t_cnt               pend_idx;
    t_cnt               flush_n;
    t_byte              extra;
    logic               has_extra;
    logic               stay;

    assign cnt    = (r_cnt > t_cnt'(PEND_DEPTH)) ? t_cnt'(PEND_DEPTH) : r_cnt;
    assign is_lt  = (i_text_byte == CH_LT);
    assign is_amp = (i_text_byte == CH_AMP);
    assign is_gt  = (i_text_byte == CH_GT);
    assign f_mode = is_lt ? MODE_TAG_OPEN : (is_amp ? MODE_ENTITY : MODE_NORMAL);
    assign f_lit  = !is_lt && !is_amp;

    // Pending bytes plus the new byte compared against every entity at once.
    always_comb begin
        pfx_ok = '0;
        full   = '0;
        dec    = '0;
        for (int k = 0; k < ENT_NUM; k++) begin
            pfx_ok[k] = (cnt < ENT_LEN[k]);
            for (int j = 0; j < PEND_DEPTH; j++) begin
                if (t_cnt'(j) < cnt && r_pend[j] != ENT_TXT[k][j]) begin
                    pfx_ok[k] = 1'b0;
                end
            end
            for (int j = 0; j < ENT_MAX_LEN; j++) begin
                if (t_cnt'(j) == cnt && i_text_byte != ENT_TXT[k][j]) begin
                    pfx_ok[k] = 1'b0;
                end
            end
            full[k] = pfx_ok[k] && (t_cnt'(cnt + 3'd1) == ENT_LEN[k]);
            if (full[k]) begin
                dec = ENT_DEC[k];
            end
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_cnt     = r_cnt;
        pend_wr   = 1'b0;
        pend_idx  = '0;
        flush_n   = '0;
        extra     = '0;
        has_extra = 1'b0;
        stay      = 1'b0;

        case (r_mode)
            MODE_TAG_OPEN: begin
                if (is_gt) begin
                    n_mode = MODE_NORMAL;
                end else if (i_text_byte == CH_B_L || i_text_byte == CH_B_U) begin
                    n_mode = MODE_TAG_B;
                end else begin
                    n_mode = MODE_TAG_BODY;
                end
            end
            MODE_TAG_B: begin
                if (is_gt) begin
                    n_mode = MODE_NORMAL;
                end else begin
                    if (i_text_byte == CH_R_L || i_text_byte == CH_R_U) begin
                        extra     = CH_NL;
                        has_extra = 1'b1;
                    end
                    n_mode = MODE_TAG_BODY;
                end
            end
            MODE_TAG_BODY: begin
                if (is_gt) begin
                    n_mode = MODE_NORMAL;
                end
            end
            MODE_ENTITY: begin
                if (|full) begin
                    extra     = dec;
                    has_extra = 1'b1;
                    n_cnt     = '0;
                    n_mode    = MODE_NORMAL;
                end else if ((|pfx_ok) && cnt < t_cnt'(PEND_DEPTH)) begin
                    stay     = 1'b1;
                    pend_wr  = 1'b1;
                    pend_idx = cnt;
                    n_cnt    = t_cnt'(cnt + 3'd1);
                end else begin
                    // Broken entity: the old bytes go out, the new byte starts afresh.
                    flush_n = cnt;
                    n_cnt   = '0;
                    n_mode  = f_mode;
                    if (is_amp) begin
                        pend_wr = 1'b1;
                        n_cnt   = 3'd1;
                    end
                    extra     = i_text_byte;
                    has_extra = f_lit;
                end
            end
            default: begin
                n_mode = f_mode;
                if (is_amp) begin
                    pend_wr = 1'b1;
                    n_cnt   = 3'd1;
                end
                extra     = i_text_byte;
                has_extra = f_lit;
            end
        endcase

        // At the end of the text a pending entity goes out as literals; its
        // last byte is always the byte just taken.
        if (i_final_byte) begin
            if (n_mode == MODE_ENTITY) begin
                extra     = i_text_byte;
                has_extra = 1'b1;
                if (stay) begin
                    flush_n = cnt;
                end
            end
            n_mode = MODE_NORMAL;
            n_cnt  = '0;
        end
    end

    always_comb begin
        o_burst.num = t_cnt'(flush_n + t_cnt'(has_extra));
        o_burst.has = has_extra || (flush_n != '0);
        o_burst.fin = i_final_byte;
        for (int i = 0; i < PEND_DEPTH; i++) begin
            o_burst.chars[i] = (t_cnt'(i) < flush_n) ? r_pend[i] : extra;
        end
        o_burst.chars[MAX_RES-1] = extra;
        // The empty end marker carries a zero byte.
        if (i_final_byte && o_burst.num == '0) begin
            o_burst.num      = 3'd1;
            o_burst.chars[0] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_cnt  <= '0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
            if (pend_wr) begin
                r_pend[pend_idx] <= i_text_byte;
            end
        end
    end

endmodule

>>> hw/rtl/mes_burst.sv
// ----------------------------------------------------------------------------
// Markup entity stripper result buffer
// Registers one item's burst, handing out one result per ready output cycle.
// ----------------------------------------------------------------------------
`include "markup_entity_stripper_top_assert.svh"

module mes_burst (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  mes_pkg::t_burst i_burst,
    output logic            o_in_ready,
    mes_out_if.source       o_out
);
    import mes_pkg::*;

    logic [MAX_RES-1:0][BYTE_W-1:0] r_chars;
    t_cnt                           r_left;
    logic                           r_has;
    logic                           r_fin;
    logic                           out_fire;

    assign out_fire   = o_out.valid && o_out.ready;
    assign o_in_ready = (r_left == '0) || (r_left == 3'd1 && o_out.ready);

    assign o_out.valid     = (r_left != '0);
    assign o_out.out_char  = r_chars[0];
    assign o_out.has_char  = r_has;
    assign o_out.run_end   = (r_left == 3'd1);
    assign o_out.text_done = (r_left == 3'd1) && r_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_fire) begin
            r_left <= i_burst.num;
        end else if (out_fire) begin
            r_left <= t_cnt'(r_left - 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_chars <= i_burst.chars;
            r_has   <= i_burst.has;
            r_fin   <= i_burst.fin;
        end else if (out_fire) begin
            r_chars <= {BYTE_W'(0), r_chars[MAX_RES-1:1]};
        end
    end

    `MES_ASSERT_IMP(a_ready_only_near_empty, i_clk, i_rst_n, o_in_ready, r_left <= 3'd1)
    `MES_ASSERT_NXT(a_burst_loaded, i_clk, i_rst_n, i_fire, r_left == $past(i_burst.num))
    `MES_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, o_out.valid && !o_out.ready,
                    $stable(r_left) && $stable(r_chars[0]))
    `MES_ASSERT_IMP(a_left_bounded, i_clk, i_rst_n, 1'b1, r_left <= t_cnt'(MAX_RES))

endmodule

>>> hw/rtl/markup_entity_stripper_top.sv
// ----------------------------------------------------------------------------
// Markup entity stripper, top level
// The first result of an item is offered in the cycle after it is taken.
// Throughput: one item per cycle while items give at most one result and the
// output is ready; an item with more than one result holds the input until its
// last result is being taken, as the buffer gives one result per ready cycle.
// Reset: synchronous, active low; clears the scan mode, pending count and buffer.
// ----------------------------------------------------------------------------
//
// Subtitle text arrives one byte per item. Tags are dropped, with a newline
// for a tag that opens with br in either case, and the five entities
// &amp; &lt; &gt; &quot; &#39; are decoded. An entity that cannot complete
// is sent on as its literal bytes and the byte that broke it is then scanned
// as ordinary text. The scanner works out every result of an item in the
// cycle the item is accepted and loads them all into the result buffer,
// which offers them in order, one per cycle while the output is ready. The
// last result of an item carries run_end; the last of the text adds text_done.
// A final byte that yields nothing still produces an empty end marker.
//
// No memory needs clearing after reset: the pending entity bytes are only
// read below the pending count, which reset clears.
module markup_entity_stripper_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mes_in_if.sink    i_in,
    mes_out_if.source o_out
);
    import mes_pkg::*;

    logic   in_fire;
    logic   in_ready;
    t_burst burst;

    // The buffer accepts a new item when it is empty or its last result is
    // being taken in this very cycle.
    assign i_in.ready = in_ready;
    assign in_fire    = i_in.valid && in_ready;

    mes_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (in_fire),
        .i_text_byte  (i_in.text_byte),
        .i_final_byte (i_in.final_byte),
        .o_burst      (burst)
    );

    mes_burst u_burst (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (in_fire),
        .i_burst    (burst),
        .o_in_ready (in_ready),
        .o_out      (o_out)
    );

endmodule
